### rtl/srrip_pkg.sv
package srrip_pkg;

  localparam int SETS  = 2048;
  localparam int WAYS  = 16;
  localparam int SET_W = 11;
  localparam int WAY_W = 4;
  localparam int ROW_W = WAYS * 2;

  typedef logic [1:0] rrpv_t;
  typedef logic [1:0] op_t;

  localparam op_t OP_VICTIM = 2'd0;
  localparam op_t OP_HIT    = 2'd1;
  localparam op_t OP_FILL   = 2'd2;

  localparam rrpv_t RRPV_MAX  = 2'd3;
  localparam rrpv_t RRPV_FILL = 2'd2;
  localparam rrpv_t RRPV_HIT  = 2'd0;

  typedef struct packed {
    logic  cand;
    rrpv_t rrpv;
  } lane_res_t;

  typedef logic [SET_W-1:0] set_t;
  typedef logic [WAY_W-1:0] way_t;
  typedef logic [ROW_W-1:0] row_t;

endpackage

### rtl/srrip_lane.sv
module srrip_lane (
  input  srrip_pkg::rrpv_t     rrpv,
  input  logic                 elig,
  input  srrip_pkg::rrpv_t     age,
  output srrip_pkg::lane_res_t res
);
  import srrip_pkg::*;

  logic [2:0] sum;
  rrpv_t      aged;

  always_comb begin
    sum  = {1'b0, rrpv} + {1'b0, age};
    aged = sum[2] ? RRPV_MAX : sum[1:0];
    res.rrpv = elig ? aged : rrpv;
    res.cand = elig && (res.rrpv == RRPV_MAX);
  end

endmodule

### rtl/srrip_merge.sv
module srrip_merge (
  input  srrip_pkg::row_t                        row,
  input  logic [srrip_pkg::WAYS-1:0]             prot,
  input  srrip_pkg::lane_res_t [srrip_pkg::WAYS-1:0] lane_res,
  output logic [srrip_pkg::WAYS-1:0]             elig,
  output srrip_pkg::rrpv_t                       age,
  output srrip_pkg::way_t                        victim_way
);
  import srrip_pkg::*;

  logic             any_free;
  logic [WAYS-1:0]  v_hi;
  logic [WAYS-1:0]  v_lo;
  logic [WAYS-1:0]  cand;
  rrpv_t            top;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      v_hi[w] = row[2*w+1];
      v_lo[w] = row[2*w];
      cand[w] = lane_res[w].cand;
    end
    any_free = |(~prot);
    elig     = any_free ? ~prot : {WAYS{1'b1}};
    top[1]   = |(elig & v_hi);
    top[0]   = |(elig & v_lo & ~(v_hi ^ {WAYS{top[1]}}));
    if (any_free && top == RRPV_MAX) begin
      age = 2'd1;
    end else begin
      age = RRPV_MAX - top;
    end
    victim_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (cand[w]) begin
        victim_way = way_t'(w);
      end
    end
  end

endmodule

### rtl/srrip_replacement_with_protected_ways_unit.sv
// Each transaction is a read-modify-write of one set row in the single-port
// RRPV row memory: the row is read into rdata_r on accept and updated in
// S_CALC, which also registers a victim; in_stall is high until S_CALC ends.
// Reset: rst_n is synchronous, active low. After reset a clearing pass writes
// all 2048 rows to RRPV 3, one row a cycle, with in_stall held high.
module srrip_replacement_with_protected_ways_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  srrip_pkg::op_t       in_operation,
  input  srrip_pkg::set_t      in_set_index,
  input  srrip_pkg::way_t      in_way,
  input  logic [15:0]          in_protected_mask,
  output logic                 out_valid,
  input  logic                 out_stall,
  output srrip_pkg::way_t      out_victim_way
);
  import srrip_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_CALC  = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  set_t            clr_cnt_r, clr_cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  way_t            out_way_r, out_way_nxt;
  op_t             op_r;
  set_t            set_r;
  way_t            way_r;
  logic [WAYS-1:0] prot_r;
  row_t            rdata_r;

  row_t            mem [SETS];
  logic            accept;
  logic            hold;
  logic            we;
  set_t            waddr;
  row_t            wdata;
  row_t            upd_row;
  row_t            aged_row;

  logic [WAYS-1:0]         elig;
  rrpv_t                   age;
  way_t                    victim;
  lane_res_t [WAYS-1:0]    lane_res;

  for (genvar g = 0; g < WAYS; g++) begin : g_lane
    srrip_lane u_lane (
      .rrpv (rdata_r[2*g+1:2*g]),
      .elig (elig[g]),
      .age  (age),
      .res  (lane_res[g])
    );
    assign aged_row[2*g+1:2*g] = lane_res[g].rrpv;
  end

  srrip_merge u_merge (
    .row        (rdata_r),
    .prot       (prot_r),
    .lane_res   (lane_res),
    .elig       (elig),
    .age        (age),
    .victim_way (victim)
  );

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign hold      = (op_r == OP_VICTIM) && out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_victim_way = out_way_r;

  always_comb begin
    upd_row = rdata_r;
    upd_row[2*way_r +: 2] = (op_r == OP_HIT) ? RRPV_HIT : RRPV_FILL;
  end

  always_comb begin
    we    = 1'b0;
    waddr = set_r;
    wdata = aged_row;
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_way_nxt   = out_way_r;
    case (state_r)
      S_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_cnt_r;
        wdata       = '1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == set_t'(SETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (!hold) begin
          state_nxt = S_IDLE;
          case (op_r)
            OP_VICTIM: begin
              we            = 1'b1;
              wdata         = aged_row;
              out_valid_nxt = 1'b1;
              out_way_nxt   = victim;
            end
            OP_HIT, OP_FILL: begin
              we    = 1'b1;
              wdata = upd_row;
            end
            default: begin
              we = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_way_r <= out_way_nxt;
    if (accept) begin
      op_r   <= in_operation;
      set_r  <= in_set_index;
      way_r  <= in_way;
      prot_r <= in_protected_mask[WAYS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (accept) begin
      rdata_r <= mem[in_set_index];
    end
  end

endmodule

### tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srrip_pkg::*;

  localparam op_t OP_NONE      = 2'd3;
  localparam int  PHASE_ITEMS  = 150;
  localparam int  HOLD_CYCLES  = 300;
  localparam int  IDLE_LIMIT   = 8000;
  localparam int  DRAIN_CYCLES = 20;

  typedef struct packed {
    op_t         op;
    set_t        set;
    way_t        way;
    logic [15:0] mask;
  } req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  op_t         in_operation = OP_VICTIM;
  set_t        in_set_index = '0;
  way_t        in_way = '0;
  logic [15:0] in_protected_mask = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  way_t        out_victim_way;

  rrpv_t rrpv_mem [SETS][WAYS];
  req_t  pend_q[$];
  way_t  expected_victims[$];
  set_t  set_pool [4];

  int   snd_idle = 0;
  int   rcv_idle = 0;
  int   hold_req = 0;
  int   hold_ack = 0;
  int   hold_cnt = 0;
  int   err_cnt = 0;
  int   idle_cycles = 0;
  req_t next_req;
  way_t exp_way;

  srrip_replacement_with_protected_ways_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_set_index      (in_set_index),
    .in_way            (in_way),
    .in_protected_mask (in_protected_mask),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_victim_way    (out_victim_way)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // age the unprotected ways (or all ways if none is free) and return the victim
  function automatic way_t pick_victim(set_t s, logic [15:0] m);
    int  top_free = 0;
    int  top_all = 0;
    bit  any_free = 0;
    int  age;
    int  v;
    for (int w = 0; w < WAYS; w++) begin
      v = rrpv_mem[s][w];
      if (v > top_all) top_all = v;
      if (!m[w]) begin
        any_free = 1;
        if (v > top_free) top_free = v;
      end
    end
    if (any_free) begin
      age = int'(RRPV_MAX) - top_free;
      if (age < 1) age = 1;
    end else begin
      age = int'(RRPV_MAX) - top_all;
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!any_free || !m[w]) begin
        v = rrpv_mem[s][w] + age;
        rrpv_mem[s][w] = (v > int'(RRPV_MAX)) ? RRPV_MAX : rrpv_t'(v);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if ((!any_free || !m[w]) && rrpv_mem[s][w] == RRPV_MAX) return way_t'(w);
    end
    return '0;
  endfunction

  function automatic void apply_request(op_t op, set_t s, way_t w, logic [15:0] m);
    case (op)
      OP_VICTIM: expected_victims.push_back(pick_victim(s, m));
      OP_HIT:    rrpv_mem[s][w] = RRPV_HIT;
      OP_FILL:   rrpv_mem[s][w] = RRPV_FILL;
      default:   ;
    endcase
  endfunction

  function automatic req_t make_req(op_t op, set_t s, way_t w, logic [15:0] m);
    req_t r;
    r.op = op;
    r.set = s;
    r.way = w;
    r.mask = m;
    return r;
  endfunction

  function automatic req_t rand_request();
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 35) r.op = OP_VICTIM;
    else if (pick < 65) r.op = OP_HIT;
    else if (pick < 90) r.op = OP_FILL;
    else r.op = OP_NONE;
    if ($urandom_range(99) < 85) r.set = set_pool[$urandom_range(3)];
    else r.set = set_t'($urandom);
    r.way = way_t'($urandom);
    pick = $urandom_range(99);
    if (pick < 25) r.mask = 16'h0000;
    else if (pick < 40) r.mask = 16'hFFFF;
    else if (pick < 60) r.mask = ~(16'h1 << $urandom_range(15));
    else r.mask = 16'($urandom);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) apply_request(in_operation, in_set_index, in_way, in_protected_mask);
      if (pend_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
        next_req = pend_q.pop_front();
        in_valid          <= 1'b1;
        in_operation      <= next_req.op;
        in_set_index      <= next_req.set;
        in_way            <= next_req.way;
        in_protected_mask <= next_req.mask;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
      hold_ack  <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_cnt  <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_victims.size() == 0) begin
        if (err_cnt < 10) $display("unexpected transaction: victim_way %0d", out_victim_way);
        err_cnt++;
      end else begin
        exp_way = expected_victims.pop_front();
        if (out_victim_way !== exp_way) begin
          if (err_cnt < 10)
            $display("victim_way mismatch: expected %0d, got %0d", exp_way, out_victim_way);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("srrip_replacement_with_protected_ways_unit regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    for (int s = 0; s < SETS; s++)
      for (int w = 0; w < WAYS; w++)
        rrpv_mem[s][w] = RRPV_MAX;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 3; ph++) begin
      @(negedge clk);
      case (ph)
        0: begin snd_idle = 36; rcv_idle = 78; end
        1: begin snd_idle = 78; rcv_idle = 36; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      for (int i = 0; i < 4; i++) set_pool[i] = set_t'($urandom);

      if (ph == 0) begin
        pend_q.push_back(make_req(OP_VICTIM, 11'h000, 4'd0, 16'h0000));
        pend_q.push_back(make_req(OP_HIT, 11'h000, 4'd0, 16'hFFFF));
        pend_q.push_back(make_req(OP_FILL, 11'h000, 4'd1, 16'h0000));
        pend_q.push_back(make_req(OP_VICTIM, 11'h000, 4'd15, 16'h0000));
        pend_q.push_back(make_req(OP_VICTIM, 11'h000, 4'd0, 16'hFFFF));
        // lone free way at RRPV 0 gets the full age of 3
        pend_q.push_back(make_req(OP_HIT, 11'h7FF, 4'd15, 16'h0000));
        pend_q.push_back(make_req(OP_VICTIM, 11'h7FF, 4'd0, 16'h7FFF));
        pend_q.push_back(make_req(OP_NONE, 11'h7FF, 4'd15, 16'hFFFF));
        // whole set below 3, then every way protected
        pend_q.push_back(make_req(OP_HIT, 11'h2AA, 4'd0, 16'h0000));
        for (int w = 1; w < WAYS; w++)
          pend_q.push_back(make_req(OP_FILL, 11'h2AA, way_t'(w), 16'h0000));
        pend_q.push_back(make_req(OP_VICTIM, 11'h2AA, 4'd0, 16'hFFFF));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) pend_q.push_back(rand_request());
      if (ph == 2) hold_req++;
      while (pend_q.size() != 0) @(negedge clk);
    end

    while (in_valid) @(negedge clk);
    while (expected_victims.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_victims.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("srrip_replacement_with_protected_ways_unit regression: pass");
    end else begin
      $display("srrip_replacement_with_protected_ways_unit regression: fail");
    end
    $finish;
  end

endmodule
